// ===== design/hvsg_pkg.sv =====
// hvsg_pkg: shared constants, register indexes and saturation helper
// for the hashed voxel spawn generator; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hvsg_pkg;

    // hash constants
    localparam logic [31:0] MIX_MUL1   = 32'h7feb352d;
    localparam logic [31:0] MIX_MUL2   = 32'h846ca68b;
    localparam logic [31:0] GOLDEN     = 32'h9e3779b9;
    localparam logic [31:0] SEED_MUL_Z = 32'd17;
    localparam logic [31:0] SEED_MUL_Y = 32'd31;

    // field widths
    localparam int IDX_W   = 32;
    localparam int CELL_W  = 13;
    localparam int VCELL_W = 16;
    localparam int VOX_W   = 25;
    localparam int FALL_W  = 31;
    localparam int LANE_W  = 26;
    localparam int POS_W   = 32;
    localparam int U_W     = 24;

    // smallest voxel edge, 0.05 in Q16.16
    localparam logic [VOX_W-1:0] MIN_VOXEL = 25'd3277;
    // 0.75 in units of 2^-25
    localparam logic [LANE_W-1:0] SPEED_BASE = 26'h1800000;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_SEED   = 3'd0,
        REG_WIDTH  = 3'd1,
        REG_DEPTH  = 3'd2,
        REG_VERT   = 3'd3,
        REG_VOXEL  = 3'd4,
        REG_HEIGHT = 3'd5,
        REG_FALL   = 3'd6
    } reg_index_t;

    // clamp a wide signed value to the signed 32-bit range
    function automatic logic [POS_W-1:0] sat32(input logic signed [42:0] v);
        logic [POS_W-1:0] r;
        if (v > 43'sd2147483647)
            r = 32'h7fffffff;
        else if (v < -43'sd2147483648)
            r = 32'h80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/hvsg_div_cell.sv =====
// hvsg_div_cell: one restoring division step for several lanes, registered
// depends on nothing outside this file
`timescale 1ns / 1ps
`default_nettype none

module hvsg_div_cell #(
    parameter int LANES  = 1,
    parameter int NUM_W  = 32,
    parameter int DEN_W  = 16,
    parameter int SIDE_W = 1
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              en,
    input  wire logic [LANES-1:0][DEN_W-1:0]       den,
    input  wire logic                              in_valid,
    input  wire logic [LANES-1:0][DEN_W-1:0]       in_rem,
    input  wire logic [LANES-1:0][NUM_W-1:0]       in_nq,
    input  wire logic [SIDE_W-1:0]                 in_side,
    output logic                                   out_valid,
    output logic [LANES-1:0][DEN_W-1:0]            out_rem,
    output logic [LANES-1:0][NUM_W-1:0]            out_nq,
    output logic [SIDE_W-1:0]                      out_side
);

    logic                              valid_reg;
    logic [LANES-1:0][DEN_W-1:0]       rem_reg, rem_next;
    logic [LANES-1:0][NUM_W-1:0]       nq_reg, nq_next;
    logic [SIDE_W-1:0]                 side_reg;
    logic [LANES-1:0][DEN_W:0]         trial;
    logic [LANES-1:0][DEN_W:0]         diff;
    logic [LANES-1:0]                  fits;

    // shift in the next numerator bit, subtract when the divisor fits
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            trial[l]    = {in_rem[l], in_nq[l][NUM_W-1]};
            diff[l]     = trial[l] - {1'b0, den[l]};
            fits[l]     = trial[l] >= {1'b0, den[l]};
            rem_next[l] = fits[l] ? diff[l][DEN_W-1:0] : trial[l][DEN_W-1:0];
            nq_next[l]  = {in_nq[l][NUM_W-2:0], fits[l]};
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            nq_reg   <= nq_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_nq    = nq_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

// ===== design/hvsg_div_chain.sv =====
// hvsg_div_chain: row of division cells, one quotient bit per cell
// depends on hvsg_div_cell
`timescale 1ns / 1ps
`default_nettype none

module hvsg_div_chain #(
    parameter int LANES  = 1,
    parameter int NUM_W  = 32,
    parameter int DEN_W  = 16,
    parameter int SIDE_W = 1
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              en,
    input  wire logic [LANES-1:0][DEN_W-1:0]       den,
    input  wire logic                              in_valid,
    input  wire logic [LANES-1:0][NUM_W-1:0]       in_num,
    input  wire logic [SIDE_W-1:0]                 in_side,
    output logic                                   out_valid,
    output logic [LANES-1:0][NUM_W-1:0]            out_quo,
    output logic [LANES-1:0][DEN_W-1:0]            out_rem,
    output logic [SIDE_W-1:0]                      out_side
);

    logic [NUM_W:0]                            v_w;
    logic [NUM_W:0][LANES-1:0][DEN_W-1:0]      rem_w;
    logic [NUM_W:0][LANES-1:0][NUM_W-1:0]      nq_w;
    logic [NUM_W:0][SIDE_W-1:0]                side_w;

    // chain head: remainder starts at zero
    assign v_w[0]    = in_valid;
    assign rem_w[0]  = '0;
    assign nq_w[0]   = in_num;
    assign side_w[0] = in_side;

    for (genvar k = 0; k < NUM_W; k++)
    begin : g_cell
        hvsg_div_cell #(
            .LANES  (LANES),
            .NUM_W  (NUM_W),
            .DEN_W  (DEN_W),
            .SIDE_W (SIDE_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .den       (den),
            .in_valid  (v_w[k]),
            .in_rem    (rem_w[k]),
            .in_nq     (nq_w[k]),
            .in_side   (side_w[k]),
            .out_valid (v_w[k+1]),
            .out_rem   (rem_w[k+1]),
            .out_nq    (nq_w[k+1]),
            .out_side  (side_w[k+1])
        );
    end

    assign out_valid = v_w[NUM_W];
    assign out_quo   = nq_w[NUM_W];
    assign out_rem   = rem_w[NUM_W];
    assign out_side  = side_w[NUM_W];

endmodule

`default_nettype wire

// ===== design/hvsg_mix.sv =====
// hvsg_mix: two-stage xorshift-multiply hash over several lanes
// depends on hvsg_pkg
`timescale 1ns / 1ps
`default_nettype none

module hvsg_mix #(
    parameter int LANES  = 1,
    parameter int SIDE_W = 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [LANES-1:0][31:0]        in_val,
    input  wire logic [SIDE_W-1:0]             in_side,
    output logic                               out_valid,
    output logic [LANES-1:0][31:0]             out_val,
    output logic [SIDE_W-1:0]                  out_side
);

    import hvsg_pkg::*;

    logic                          v1_reg, v2_reg;
    logic [LANES-1:0][31:0]        m1_reg, m1_next, m2_reg, m2_next;
    logic [LANES-1:0][31:0]        mix_a, mix_b;
    logic [SIDE_W-1:0]             s1_reg, s2_reg;

    // first multiply, second multiply, final fold
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            mix_a[l]   = in_val[l] ^ (in_val[l] >> 16);
            m1_next[l] = mix_a[l] * MIX_MUL1;
            mix_b[l]   = m1_reg[l] ^ (m1_reg[l] >> 15);
            m2_next[l] = mix_b[l] * MIX_MUL2;
            out_val[l] = m2_reg[l] ^ (m2_reg[l] >> 16);
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg <= m1_next;
            m2_reg <= m2_next;
            s1_reg <= in_side;
            s2_reg <= s1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_side  = s2_reg;

endmodule

`default_nettype wire

// ===== design/hvsg_skid.sv =====
// hvsg_skid: two-entry output buffer, registered ready toward the pipeline
// depends on nothing outside this file
`timescale 1ns / 1ps
`default_nettype none

module hvsg_skid #(
    parameter int DATA_W = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [DATA_W-1:0] in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [DATA_W-1:0]      out_data
);

    logic              out_valid_reg, spare_valid_reg;
    logic [DATA_W-1:0] out_data_reg, spare_data_reg;
    logic              in_fire, out_free;

    assign in_fire  = in_valid && !spare_valid_reg;
    assign out_free = out_ready || !out_valid_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg   <= spare_valid_reg || in_fire;
            spare_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            spare_valid_reg <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (out_free)
            out_data_reg <= spare_valid_reg ? spare_data_reg : in_data;
        else if (in_fire)
            spare_data_reg <= in_data;
    end

    assign in_ready  = !spare_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== design/hashed_voxel_spawn_generator.sv =====
// hashed_voxel_spawn_generator: one request per cycle while the output buffer has
// room; path: input register, division cell rows (32 + 32 + 33 cells),
// two hash stages of two registers each, one product stage and the output register.
// all stages advance together while the output buffer has room; a stalled
// output holds the pipeline. reset clears valid bits and configuration.
// depends on hvsg_pkg, hvsg_div_chain, hvsg_mix, hvsg_skid
`timescale 1ns / 1ps
`default_nettype none

module hashed_voxel_spawn_generator #(
    parameter int MAX_AXIS_CELLS = 4096
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // spawn_index
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [159:0]      m_tdata,   // pos_x, pos_y, pos_z, vel_y, index_out
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);

    import hvsg_pkg::*;

    localparam logic [CELL_W-1:0] AXIS_MAX = (MAX_AXIS_CELLS >= (1 << CELL_W)) ?
        {CELL_W{1'b1}} : CELL_W'(MAX_AXIS_CELLS);

    // configuration registers
    logic [31:0]          seed_reg;
    logic [CELL_W-1:0]    wc_reg, dc_reg;
    logic [VCELL_W-1:0]   vc_reg;
    logic [VOX_W-1:0]     vs_reg;
    logic signed [31:0]   sh_reg;
    logic [FALL_W-1:0]    fs_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
            wc_reg   <= CELL_W'(1);
            dc_reg   <= CELL_W'(1);
            vc_reg   <= VCELL_W'(1);
            vs_reg   <= VOX_W'(65536);
            sh_reg   <= '0;
            fs_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SEED:   seed_reg <= cfg_data;
                REG_WIDTH:  wc_reg   <= cfg_data[CELL_W-1:0];
                REG_DEPTH:  dc_reg   <= cfg_data[CELL_W-1:0];
                REG_VERT:   vc_reg   <= cfg_data[VCELL_W-1:0];
                REG_VOXEL:  vs_reg   <= cfg_data[VOX_W-1:0];
                REG_HEIGHT: sh_reg   <= $signed(cfg_data);
                REG_FALL:   fs_reg   <= cfg_data[FALL_W-1:0];
                default:    ;
            endcase
        end
    end

    // clamped cell counts and voxel size
    logic [CELL_W-1:0]  w_c, d_c;
    logic [VCELL_W-1:0] v_c;
    logic [VOX_W-1:0]   s_c;

    assign w_c = (wc_reg == '0) ? CELL_W'(1) : ((wc_reg > AXIS_MAX) ? AXIS_MAX : wc_reg);
    assign d_c = (dc_reg == '0) ? CELL_W'(1) : ((dc_reg > AXIS_MAX) ? AXIS_MAX : dc_reg);
    assign v_c = (vc_reg == '0) ? VCELL_W'(1) : vc_reg;
    assign s_c = (vs_reg < MIN_VOXEL) ? MIN_VOXEL : vs_reg;

    // lane count: max(3, 3h/4) limited to h
    logic [LANE_W-1:0] h_c, lanes_reg, lanes_next, lq_c;
    logic [LANE_W+1:0] l3_c;

    always_comb
    begin
        h_c  = LANE_W'(w_c) * LANE_W'(d_c);
        l3_c = (LANE_W+2)'(h_c) + (LANE_W+2)'({h_c, 1'b0});
        lq_c = l3_c[LANE_W+1:2];
        lanes_next = (lq_c < LANE_W'(3)) ? LANE_W'(3) : lq_c;
        if (lanes_next > h_c)
            lanes_next = h_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lanes_reg <= LANE_W'(1);
        else
            lanes_reg <= lanes_next;
    end

    // pipeline advance
    logic en;
    assign s_tready = en;

    // input stage
    logic              st0_valid_reg;
    logic [IDX_W-1:0]  st0_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st0_valid_reg <= 1'b0;
        else if (en)
            st0_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            st0_idx_reg <= s_tdata;
    end

    // lane and row from index / lanes
    logic              d1_valid;
    logic [IDX_W-1:0]  d1_quo, d1_idx;
    logic [LANE_W-1:0] d1_rem;

    hvsg_div_chain #(
        .LANES(1), .NUM_W(IDX_W), .DEN_W(LANE_W), .SIDE_W(IDX_W)
    ) u_div_lane (
        .clk(clk), .rst_n(rst_n), .en(en),
        .den(lanes_reg),
        .in_valid(st0_valid_reg), .in_num(st0_idx_reg), .in_side(st0_idx_reg),
        .out_valid(d1_valid), .out_quo(d1_quo), .out_rem(d1_rem), .out_side(d1_idx)
    );

    // lane hash, row phase hash and speed hash
    logic                  m1_valid;
    logic [2:0][31:0]      m1_val;
    logic [63:0]           m1_side;
    logic [31:0]           lh, yh;
    logic [U_W-1:0]        u1;

    hvsg_mix #(.LANES(3), .SIDE_W(64)) u_mix_a (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(d1_valid),
        .in_val({d1_idx ^ seed_reg ^ GOLDEN,
                 d1_idx + seed_reg * SEED_MUL_Y,
                 32'(d1_rem) ^ seed_reg}),
        .in_side({d1_quo, d1_idx}),
        .out_valid(m1_valid), .out_val(m1_val), .out_side(m1_side)
    );

    assign lh = m1_val[0];
    assign yh = m1_val[1];
    assign u1 = m1_val[2][U_W-1:0];

    // depth hash from the lane hash
    logic          m2_valid;
    logic [31:0]   zh;
    logic [151:0]  m2_side;

    hvsg_mix #(.LANES(1), .SIDE_W(152)) u_mix_b (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(m1_valid),
        .in_val(lh + seed_reg * SEED_MUL_Z),
        .in_side({lh, yh, u1, m1_side}),
        .out_valid(m2_valid), .out_val(zh), .out_side(m2_side)
    );

    // x cell, z cell and row phase
    logic                      d3_valid;
    logic [2:0][VCELL_W-1:0]   d3_rem;
    logic [87:0]               d3_side;
    logic [IDX_W-1:0]          d3_idx, d3_q;
    logic [U_W-1:0]            d3_u;

    hvsg_div_chain #(
        .LANES(3), .NUM_W(32), .DEN_W(VCELL_W), .SIDE_W(88)
    ) u_div_cells (
        .clk(clk), .rst_n(rst_n), .en(en),
        .den({v_c, VCELL_W'(d_c), VCELL_W'(w_c)}),
        .in_valid(m2_valid),
        .in_num({m2_side[119:88], zh, m2_side[151:120]}),
        .in_side(m2_side[87:0]),
        .out_valid(d3_valid), .out_quo(), .out_rem(d3_rem), .out_side(d3_side)
    );

    assign d3_idx = d3_side[31:0];
    assign d3_q   = d3_side[63:32];
    assign d3_u   = d3_side[87:64];

    // row: (row + phase) mod vertical cells
    logic                  d4_valid;
    logic [VCELL_W-1:0]    d4_rem;
    logic [81:0]           d4_side;

    hvsg_div_chain #(
        .LANES(1), .NUM_W(33), .DEN_W(VCELL_W), .SIDE_W(82)
    ) u_div_row (
        .clk(clk), .rst_n(rst_n), .en(en),
        .den(v_c),
        .in_valid(d3_valid),
        .in_num(33'(d3_q) + 33'(d3_rem[2])),
        .in_side({d3_rem[0][CELL_W-1:0], d3_rem[1][CELL_W-1:0], d3_u, d3_idx}),
        .out_valid(d4_valid), .out_quo(), .out_rem(d4_rem), .out_side(d4_side)
    );

    // product stage
    logic [CELL_W-1:0]    xi, zi;
    logic [U_W-1:0]       u4;
    logic signed [14:0]   ax, az;
    logic signed [25:0]   ss;
    logic [LANE_W-1:0]    scale;
    logic [40:0]          yprod;

    assign xi    = d4_side[81:69];
    assign zi    = d4_side[68:56];
    assign u4    = d4_side[55:32];
    assign ax    = $signed({1'b0, xi, 1'b0}) - $signed({2'b00, w_c - CELL_W'(1)});
    assign az    = $signed({1'b0, zi, 1'b0}) - $signed({2'b00, d_c - CELL_W'(1)});
    assign ss    = $signed({1'b0, s_c});
    assign scale = SPEED_BASE + LANE_W'(u4);
    assign yprod = 41'(d4_rem) * 41'(s_c);

    logic                 f1_valid_reg;
    logic signed [40:0]   px_reg, pz_reg;
    logic signed [42:0]   py_reg;
    logic [43:0]          vlo_reg, vhi_reg;
    logic [IDX_W-1:0]     f1_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f1_valid_reg <= 1'b0;
        else if (en)
            f1_valid_reg <= d4_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg     <= 41'(ax) * 41'(ss);
            pz_reg     <= 41'(az) * 41'(ss);
            py_reg     <= 43'(sh_reg) - $signed({2'b00, yprod});
            vlo_reg    <= 44'(fs_reg) * 44'(scale[12:0]);
            vhi_reg    <= 44'(fs_reg) * 44'(scale[25:13]);
            f1_idx_reg <= d4_side[31:0];
        end
    end

    // rounding to nearest, ties away from zero, and saturation
    logic signed [40:0] xr, zr;
    logic [57:0]        spd_sum;
    logic [32:0]        spd;
    logic [31:0]        vel;

    assign xr      = px_reg[40] ? (px_reg >>> 1) : ((px_reg + 41'sd1) >>> 1);
    assign zr      = pz_reg[40] ? (pz_reg >>> 1) : ((pz_reg + 41'sd1) >>> 1);
    assign spd_sum = 58'({vhi_reg, 13'b0}) + 58'(vlo_reg) + 58'(1 << 24);
    assign spd     = spd_sum[57:25];
    assign vel     = (spd > 33'h080000000) ? 32'h80000000 : 32'(~spd + 33'd1);

    // output buffer
    hvsg_skid #(.DATA_W(160)) u_skid (
        .clk(clk), .rst_n(rst_n),
        .in_valid(f1_valid_reg), .in_ready(en),
        .in_data({f1_idx_reg, vel, sat32(43'(zr)), sat32(py_reg), sat32(43'(xr))}),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata)
    );

endmodule

`default_nettype wire

// ===== design/hvsg_checker.sv =====
// hvsg_checker: port-level assertions for the spawn generator, bound to the top
// depends on hashed_voxel_spawn_generator ports only
`timescale 1ns / 1ps
`default_nettype none

module hvsg_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [31:0]  s_tdata,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [159:0] m_tdata,
    input wire logic         cfg_valid,
    input wire logic         cfg_ready,
    input wire logic [2:0]   cfg_index,
    input wire logic [31:0]  cfg_data
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // input back-pressure only with a result waiting
    a_bp: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // back-pressure follows a stalled output
    a_bp_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> $past(m_tvalid && !m_tready))
        else $error("input stalled without output stall");

    // vertical speed never points up
    a_vel: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[127] || m_tdata[127:96] == 32'd0))
        else $error("positive vertical velocity");

endmodule

bind hashed_voxel_spawn_generator hvsg_checker u_hvsg_checker (.*);

`default_nettype wire
